>>> src/aec_pkg.sv
// Shared types, constants and register map of the auto exposure controller.
package aec_pkg;

    localparam int FRAME_WIDTH_DEF  = 640;
    localparam int FRAME_HEIGHT_DEF = 480;

    localparam logic [16:0] W_RED   = 17'd19595;
    localparam logic [16:0] W_GREEN = 17'd38470;
    localparam logic [16:0] W_BLUE  = 17'd7471;

    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_AUTO_ENABLE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LUM_MIN     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LUM_MAX     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_EXP_FLOOR   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_EXP_CEIL    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_EXP_START   = 3'd5;

    localparam logic        AUTO_ENABLE_RST = 1'b0;
    localparam logic [7:0]  LUM_MIN_RST     = 8'd32;
    localparam logic [7:0]  LUM_MAX_RST     = 8'd38;
    localparam logic [15:0] EXP_FLOOR_RST   = 16'd1000;
    localparam logic [15:0] EXP_CEIL_RST    = 16'd30000;
    localparam logic [15:0] EXP_START_RST   = 16'd2600;

    localparam int WSUM_STEPS = 32;
    localparam int DIV_STEPS  = 9;
    localparam int MUL_STEPS  = 8;
    localparam int QDIV_STEPS = 24;

    localparam logic [7:0] SAT_MAX = 8'd255;

    typedef struct packed {
        logic [31:0] sum_red;
        logic [31:0] sum_green;
        logic [31:0] sum_blue;
        logic        reset_request;
    } t_aec_in;

    typedef struct packed {
        logic [7:0]  frame_luma;
        logic [7:0]  red_mean;
        logic [7:0]  green_mean;
        logic [7:0]  blue_mean;
        logic [15:0] exposure_out;
        logic        exposure_write;
    } t_aec_out;

    typedef struct packed {
        logic        auto_enable;
        logic [7:0]  lum_min;
        logic [7:0]  lum_max;
        logic [15:0] exp_floor;
        logic [15:0] exp_ceil;
        logic [15:0] exp_start;
    } t_aec_cfg;

endpackage

>>> src/aec_stream_if.sv
// Valid/ready stream interface that carries one payload per transaction.
interface aec_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/aec_regs.sv
// APB configuration register file of the auto exposure controller.
module aec_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aec_pkg::APB_AW-1:0]   paddr,
    input  logic [aec_pkg::APB_DW-1:0]   pwdata,
    output logic [aec_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output aec_pkg::t_aec_cfg            o_cfg
);

    aec_pkg::t_aec_cfg                  r_cfg;
    logic [aec_pkg::REG_IDX_W-1:0]      idx;
    logic                               wr_en;

    assign idx    = paddr[aec_pkg::APB_AW-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auto_enable <= aec_pkg::AUTO_ENABLE_RST;
            r_cfg.lum_min     <= aec_pkg::LUM_MIN_RST;
            r_cfg.lum_max     <= aec_pkg::LUM_MAX_RST;
            r_cfg.exp_floor   <= aec_pkg::EXP_FLOOR_RST;
            r_cfg.exp_ceil    <= aec_pkg::EXP_CEIL_RST;
            r_cfg.exp_start   <= aec_pkg::EXP_START_RST;
        end else if (wr_en) begin
            unique case (idx)
                aec_pkg::REG_AUTO_ENABLE: r_cfg.auto_enable <= pwdata[0];
                aec_pkg::REG_LUM_MIN:     r_cfg.lum_min     <= pwdata[7:0];
                aec_pkg::REG_LUM_MAX:     r_cfg.lum_max     <= pwdata[7:0];
                aec_pkg::REG_EXP_FLOOR:   r_cfg.exp_floor   <= pwdata[15:0];
                aec_pkg::REG_EXP_CEIL:    r_cfg.exp_ceil    <= pwdata[15:0];
                aec_pkg::REG_EXP_START:   r_cfg.exp_start   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            aec_pkg::REG_AUTO_ENABLE: prdata = 32'(r_cfg.auto_enable);
            aec_pkg::REG_LUM_MIN:     prdata = 32'(r_cfg.lum_min);
            aec_pkg::REG_LUM_MAX:     prdata = 32'(r_cfg.lum_max);
            aec_pkg::REG_EXP_FLOOR:   prdata = 32'(r_cfg.exp_floor);
            aec_pkg::REG_EXP_CEIL:    prdata = 32'(r_cfg.exp_ceil);
            aec_pkg::REG_EXP_START:   prdata = 32'(r_cfg.exp_start);
            default:                  prdata = '0;
        endcase
    end

endmodule

>>> src/aec_wsum.sv
// Bit-serial weighted sum of the three channel sums, most significant bit first.
module aec_wsum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_red,
    input  logic [31:0] i_green,
    input  logic [31:0] i_blue,
    output logic        o_done,
    output logic [31:0] o_sum
);

    localparam int CNT_W = $clog2(aec_pkg::WSUM_STEPS);

    logic [31:0]      r_red;
    logic [31:0]      r_green;
    logic [31:0]      r_blue;
    logic [47:0]      r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [16:0]      term;
    logic [47:0]      n_acc;

    always_comb begin
        term  = (r_red[31]   ? aec_pkg::W_RED   : 17'd0)
              + (r_green[31] ? aec_pkg::W_GREEN : 17'd0)
              + (r_blue[31]  ? aec_pkg::W_BLUE  : 17'd0);
        n_acc = {r_acc[46:0], 1'b0} + 48'(term);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(aec_pkg::WSUM_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_acc   <= '0;
            r_cnt   <= '0;
        end else if (r_busy) begin
            r_red   <= {r_red[30:0], 1'b0};
            r_green <= {r_green[30:0], 1'b0};
            r_blue  <= {r_blue[30:0], 1'b0};
            r_acc   <= n_acc;
            r_cnt   <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_acc[47:16];

endmodule

>>> src/aec_sat_div.sv
// Serial restoring divider that yields a quotient saturated at 255, one bit per cycle.
module aec_sat_div #(
    parameter int DEN_W = 19
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [31:0]      i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [7:0]       o_q
);

    localparam int CW    = (DEN_W + 8 > 32) ? DEN_W + 8 : 32;
    localparam int CNT_W = $clog2(aec_pkg::DIV_STEPS);

    logic [CW-1:0]    r_rem;
    logic [CW-1:0]    r_dsh;
    logic [8:0]       r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             ge;

    assign ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(aec_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // The first step tests the numerator against 256 times the divisor.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= CW'(i_num);
            r_dsh <= CW'(i_den) << 8;
            r_q   <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? r_rem - r_dsh : r_rem;
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[7:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q[8] ? aec_pkg::SAT_MAX : r_q[7:0];

endmodule

>>> src/aec_scale.sv
// Exposure scaling: shift-add multiply by the target luma, then long division by the frame luma.
module aec_scale (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_exposure,
    input  logic [7:0]  i_lum,
    input  logic [7:0]  i_luma,
    output logic        o_done,
    output logic [23:0] o_q
);

    localparam int CNT_W = $clog2(aec_pkg::QDIV_STEPS);

    logic [23:0]      r_num;
    logic [15:0]      r_exp;
    logic [7:0]       r_lum;
    logic [7:0]       r_den;
    logic [7:0]       r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_mul;
    logic             r_busy;
    logic             r_done;
    logic [8:0]       sh;
    logic             ge;
    logic             last;

    assign sh   = {r_rem, r_num[23]};
    assign ge   = (sh >= {1'b0, r_den});
    assign last = r_mul ? (r_cnt == CNT_W'(aec_pkg::MUL_STEPS - 1))
                        : (r_cnt == CNT_W'(aec_pkg::QDIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_mul  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_mul  <= 1'b1;
            end else if (r_busy && last) begin
                if (r_mul) begin
                    r_mul <= 1'b0;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= '0;
            r_exp <= i_exposure;
            r_lum <= i_lum;
            r_den <= i_luma;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= last ? '0 : r_cnt + 1'b1;
            if (r_mul) begin
                r_num <= {r_num[22:0], 1'b0} + (r_lum[7] ? 24'(r_exp) : 24'd0);
                r_lum <= {r_lum[6:0], 1'b0};
            end else begin
                r_rem <= ge ? 8'(sh - {1'b0, r_den}) : sh[7:0];
                r_num <= {r_num[22:0], ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_num;

endmodule

>>> src/auto_exposure_controller.sv
// Auto exposure controller: frame statistics in, luma, channel means and exposure out.
// A transaction passes through the bit-serial weighted sum and the luma division and, when the
// exposure is rescaled, through the multiply and long division of the scaling unit as well.
// A new transaction is taken only in the idle state, after the result of the last is registered;
// registering waits while the output holds a result that has not been taken.
// Synchronous active-low reset clears control, loads the register reset values and exposure 2600.
module auto_exposure_controller #(
    parameter int FRAME_WIDTH  = aec_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = aec_pkg::FRAME_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    aec_stream_if.sink                  i_pix,
    aec_stream_if.source                o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aec_pkg::APB_AW-1:0]  paddr,
    input  logic [aec_pkg::APB_DW-1:0]  pwdata,
    output logic [aec_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int PIX      = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int PIX_W    = $clog2(PIX + 1);
    localparam int DEN_HALF = (PIX / 2 == 0) ? 1 : PIX / 2;
    localparam int DEN_QTR  = (PIX / 4 == 0) ? 1 : PIX / 4;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SUM   = 5'b00010,
        S_LUMA  = 5'b00100,
        S_SCALE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state             r_state;
    aec_pkg::t_aec_cfg  cfg;
    aec_pkg::t_aec_out  r_out;
    logic               r_out_valid;
    logic [15:0]        r_ev;
    logic               r_settle;
    logic               r_rst_req;
    logic               r_wr;
    logic               r_raise;

    logic               accept;
    logic               wsum_done;
    logic [31:0]        wsum;
    logic               luma_done;
    logic [7:0]         luma;
    logic [7:0]         red_mean;
    logic [7:0]         green_mean;
    logic [7:0]         blue_mean;
    logic               scale_start;
    logic               scale_done;
    logic [23:0]        scale_q;
    logic               raise;
    logic               lower;
    logic               load;
    logic [15:0]        n_ev;
    logic [15:0]        ev_final;

    aec_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign accept      = i_pix.valid & i_pix.ready;
    assign i_pix.ready = (r_state == S_IDLE);

    aec_wsum u_wsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_red   (i_pix.data.sum_red),
        .i_green (i_pix.data.sum_green),
        .i_blue  (i_pix.data.sum_blue),
        .o_done  (wsum_done),
        .o_sum   (wsum)
    );

    aec_sat_div #(.DEN_W(PIX_W)) u_div_red (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_num   (i_pix.data.sum_red),
        .i_den   (PIX_W'(DEN_QTR)),
        .o_done  (),
        .o_q     (red_mean)
    );

    aec_sat_div #(.DEN_W(PIX_W)) u_div_green (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_num   (i_pix.data.sum_green),
        .i_den   (PIX_W'(DEN_HALF)),
        .o_done  (),
        .o_q     (green_mean)
    );

    aec_sat_div #(.DEN_W(PIX_W)) u_div_blue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_num   (i_pix.data.sum_blue),
        .i_den   (PIX_W'(DEN_QTR)),
        .o_done  (),
        .o_q     (blue_mean)
    );

    aec_sat_div #(.DEN_W(PIX_W)) u_div_luma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_SUM) && wsum_done),
        .i_num   (wsum),
        .i_den   (PIX_W'(PIX)),
        .o_done  (luma_done),
        .o_q     (luma)
    );

    always_comb begin
        raise = cfg.auto_enable && !r_settle && (luma < cfg.lum_min)
                && (r_ev < cfg.exp_ceil);
        lower = cfg.auto_enable && !r_settle && !raise && (luma > cfg.lum_max)
                && (r_ev > cfg.exp_floor);
        scale_start = (r_state == S_LUMA) && luma_done && (raise || lower) && (luma != 8'd0);
    end

    aec_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (scale_start),
        .i_exposure (r_ev),
        .i_lum      (raise ? cfg.lum_min : cfg.lum_max),
        .i_luma     (luma),
        .o_done     (scale_done),
        .o_q        (scale_q)
    );

    always_comb begin
        if (r_raise) begin
            n_ev = (scale_q > 24'(cfg.exp_ceil)) ? cfg.exp_ceil : scale_q[15:0];
        end else begin
            n_ev = (scale_q[15:0] < cfg.exp_floor) ? cfg.exp_floor : scale_q[15:0];
        end
        ev_final = r_rst_req ? cfg.exp_start : r_ev;
        load     = (r_state == S_DONE) && (!r_out_valid || o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ev        <= aec_pkg::EXP_START_RST;
            r_settle    <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (wsum_done) begin
                        r_state <= S_LUMA;
                    end
                end
                S_LUMA: begin
                    if (luma_done) begin
                        if (cfg.auto_enable && r_settle) begin
                            r_settle <= 1'b0;
                        end
                        if (raise && luma == 8'd0) begin
                            r_ev     <= cfg.exp_ceil;
                            r_settle <= 1'b1;
                            r_state  <= S_DONE;
                        end else if (raise || lower) begin
                            r_state <= S_SCALE;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCALE: begin
                    if (scale_done) begin
                        r_ev     <= n_ev;
                        r_settle <= 1'b1;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load) begin
                        r_ev        <= ev_final;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rst_req <= i_pix.data.reset_request;
            r_wr      <= 1'b0;
        end
        if ((r_state == S_LUMA) && luma_done) begin
            r_raise <= raise;
            if (raise && luma == 8'd0) begin
                r_wr <= 1'b1;
            end
        end
        if ((r_state == S_SCALE) && scale_done) begin
            r_wr <= 1'b1;
        end
        if (load) begin
            r_out.frame_luma     <= luma;
            r_out.red_mean       <= red_mean;
            r_out.green_mean     <= green_mean;
            r_out.blue_mean      <= blue_mean;
            r_out.exposure_out   <= ev_final;
            r_out.exposure_write <= r_wr | r_rst_req;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

>>> src/aec_checker.sv
// Port-level checker of the auto exposure controller and its bind to the top level.
module aec_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input aec_pkg::t_aec_out i_out_data
);

    // A frame in work blocks the next one until its result is registered.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted while a frame is still in work");

    // A new result only comes from a frame that was in work.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a frame in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed or was dropped");

    // Leaving reset the block is empty and ready for a frame.
    a_reset_state: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (i_in_ready && !i_out_valid))
        else $error("block not idle after reset");

endmodule

bind auto_exposure_controller aec_checker u_aec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

>>> tb/tb_auto_exposure_controller.sv
`timescale 1ns / 100ps
// Self-checking testbench for the auto exposure controller with a frame-level exposure predictor.
module tb_auto_exposure_controller;
    import aec_pkg::*;

    localparam int unsigned PIX         = FRAME_WIDTH_DEF * FRAME_HEIGHT_DEF;
    localparam int          DARK_SCENE  = -1;
    localparam int          FULL_SCENE  = 256;
    localparam int          STALL_LIMIT = 3000;
    localparam int          TAIL_CYCLES = 120;
    localparam int          RANDOM_PHASES = 7;
    localparam int          PHASE_FRAMES  = 72;

    class aec_frame_predictor;
        t_aec_cfg    cfg;
        logic [15:0] exposure;
        bit          settling;
        t_aec_out    expected_stats[$];
        int          mismatches;

        function new();
            cfg.auto_enable = AUTO_ENABLE_RST;
            cfg.lum_min     = LUM_MIN_RST;
            cfg.lum_max     = LUM_MAX_RST;
            cfg.exp_floor   = EXP_FLOOR_RST;
            cfg.exp_ceil    = EXP_CEIL_RST;
            cfg.exp_start   = EXP_START_RST;
            exposure        = EXP_START_RST;
            settling        = 1'b0;
            mismatches      = 0;
        endfunction

        function void write_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                REG_AUTO_ENABLE: cfg.auto_enable = value[0];
                REG_LUM_MIN:     cfg.lum_min     = value[7:0];
                REG_LUM_MAX:     cfg.lum_max     = value[7:0];
                REG_EXP_FLOOR:   cfg.exp_floor   = value[15:0];
                REG_EXP_CEIL:    cfg.exp_ceil    = value[15:0];
                REG_EXP_START:   cfg.exp_start   = value[15:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] sat_quot(longint unsigned num, longint unsigned den);
            longint unsigned q;
            q = num / den;
            return (q > 255) ? SAT_MAX : 8'(q);
        endfunction

        function void note_frame(t_aec_in fr);
            longint unsigned weighted;
            logic [7:0]      luma;
            int unsigned     scaled;
            t_aec_out        res;
            weighted = 64'(W_RED) * 64'(fr.sum_red) + 64'(W_GREEN) * 64'(fr.sum_green)
                     + 64'(W_BLUE) * 64'(fr.sum_blue);
            luma = sat_quot(weighted, 64'(PIX) << 16);
            res.exposure_write = 1'b0;
            if (cfg.auto_enable) begin
                if (settling) begin
                    settling = 1'b0;
                end else if (luma < cfg.lum_min && exposure < cfg.exp_ceil) begin
                    if (luma == 0) begin
                        scaled = cfg.exp_ceil;
                    end else begin
                        scaled = (32'(exposure) * 32'(cfg.lum_min)) / 32'(luma);
                        if (scaled > cfg.exp_ceil) scaled = cfg.exp_ceil;
                    end
                    exposure = scaled[15:0];
                    settling = 1'b1;
                    res.exposure_write = 1'b1;
                end else if (luma > cfg.lum_max && exposure > cfg.exp_floor) begin
                    scaled = (32'(exposure) * 32'(cfg.lum_max)) / 32'(luma);
                    if (scaled < cfg.exp_floor) scaled = cfg.exp_floor;
                    exposure = scaled[15:0];
                    settling = 1'b1;
                    res.exposure_write = 1'b1;
                end
            end
            if (fr.reset_request) begin
                exposure = cfg.exp_start;
                res.exposure_write = 1'b1;
            end
            res.frame_luma   = luma;
            res.red_mean     = sat_quot(64'(fr.sum_red), PIX / 4);
            res.green_mean   = sat_quot(64'(fr.sum_green), PIX / 2);
            res.blue_mean    = sat_quot(64'(fr.sum_blue), PIX / 4);
            res.exposure_out = exposure;
            expected_stats.push_back(res);
        endfunction

        function void check_frame(t_aec_out got);
            t_aec_out want;
            if (expected_stats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected frame result: luma %0d exposure %0d write %0d",
                             got.frame_luma, got.exposure_out, got.exposure_write);
                return;
            end
            want = expected_stats.pop_front();
            if (got.frame_luma !== want.frame_luma || got.red_mean !== want.red_mean ||
                got.green_mean !== want.green_mean || got.blue_mean !== want.blue_mean ||
                got.exposure_out !== want.exposure_out ||
                got.exposure_write !== want.exposure_write) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("frame result mismatch (expected/actual): luma %0d/%0d red %0d/%0d",
                             want.frame_luma, got.frame_luma, want.red_mean, got.red_mean);
                    $display("  green %0d/%0d blue %0d/%0d exposure %0d/%0d write %0d/%0d",
                             want.green_mean, got.green_mean, want.blue_mean, got.blue_mean,
                             want.exposure_out, got.exposure_out,
                             want.exposure_write, got.exposure_write);
                end
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    aec_stream_if #(.T(t_aec_in))  pix_if ();
    aec_stream_if #(.T(t_aec_out)) res_if ();

    aec_frame_predictor predictor = new();
    bit relaxed_source = 1'b0;
    bit relaxed_sink = 1'b0;
    int sink_hold = 0;
    int idle_cycles = 0;

    auto_exposure_controller DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        pix_if.valid = 1'b0;
        pix_if.data  = '0;
        res_if.ready = 1'b0;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || relaxed_sink) begin
            res_if.ready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            res_if.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            sink_hold <= idle_gap();
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) predictor.check_frame(res_if.data);
            if (pix_if.valid && pix_if.ready) predictor.note_frame(pix_if.data);
        end
    end

    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("auto_exposure_controller regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        predictor.write_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_frame(t_aec_in fr);
        int gap;
        gap = relaxed_source ? 0 : idle_gap();
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.data  <= fr;
        do @(posedge i_clk); while (!pix_if.ready);
    endtask

    // The extra edge lets the monitor note the last accepted frame first.
    task automatic wait_quiet();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (predictor.expected_stats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_aec_in scene_frame(int level, bit reload);
        t_aec_in fr;
        fr.reset_request = reload;
        if (level < 0) begin
            fr.sum_red   = '0;
            fr.sum_green = '0;
            fr.sum_blue  = '0;
        end else if (level > 255) begin
            fr.sum_red   = '1;
            fr.sum_green = '1;
            fr.sum_blue  = '1;
        end else begin
            fr.sum_red   = level * PIX + $urandom_range(0, PIX - 1);
            fr.sum_green = level * PIX + $urandom_range(0, PIX - 1);
            fr.sum_blue  = level * PIX + $urandom_range(0, PIX - 1);
        end
        return fr;
    endfunction

    function automatic t_aec_in random_frame();
        t_aec_in fr;
        int      pick;
        int      level;
        bit      reload;
        reload = ($urandom_range(0, 11) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            case ($urandom_range(0, 3))
                0: level = $urandom_range(0, 255);
                1: level = int'(predictor.cfg.lum_min) + int'($urandom_range(0, 8)) - 4;
                2: level = int'(predictor.cfg.lum_max) + int'($urandom_range(0, 8)) - 4;
                default: level = $urandom_range(0, 3);
            endcase
            if (level < 0) level = 0;
            if (level > 255) level = 255;
            fr = scene_frame(level, reload);
        end else if (pick < 90) begin
            fr.sum_red   = $urandom;
            fr.sum_green = $urandom;
            fr.sum_blue  = $urandom;
            fr.reset_request = reload;
        end else begin
            fr.sum_red   = $urandom_range(0, 65535);
            fr.sum_green = $urandom_range(0, 65535);
            fr.sum_blue  = $urandom_range(0, 65535);
            fr.reset_request = reload;
        end
        return fr;
    endfunction

    task automatic configure(int phase);
        logic [31:0] lmin;
        logic [31:0] emin;
        case (phase)
            0: begin
                apb_write(REG_AUTO_ENABLE, 1);
                apb_write(REG_LUM_MIN, 32);
                apb_write(REG_LUM_MAX, 38);
                apb_write(REG_EXP_FLOOR, 1000);
                apb_write(REG_EXP_CEIL, 30000);
                apb_write(REG_EXP_START, 2600);
            end
            1: begin
                apb_write(REG_AUTO_ENABLE, 1);
                apb_write(REG_LUM_MIN, 255);
                apb_write(REG_LUM_MAX, 255);
                apb_write(REG_EXP_FLOOR, 0);
                apb_write(REG_EXP_CEIL, 65535);
                apb_write(REG_EXP_START, 65535);
            end
            2: begin
                apb_write(REG_AUTO_ENABLE, 1);
                apb_write(REG_LUM_MIN, 0);
                apb_write(REG_LUM_MAX, 0);
                apb_write(REG_EXP_FLOOR, 65535);
                apb_write(REG_EXP_CEIL, 0);
                apb_write(REG_EXP_START, 0);
            end
            default: begin
                lmin = $urandom_range(0, 255);
                emin = $urandom_range(0, 65535);
                apb_write(REG_AUTO_ENABLE, (phase == 3) ? 0 : ($urandom_range(0, 3) != 0));
                apb_write(REG_LUM_MIN, lmin);
                apb_write(REG_LUM_MAX, ($urandom_range(0, 4) == 0) ?
                          $urandom_range(0, 255) : $urandom_range(lmin, 255));
                apb_write(REG_EXP_FLOOR, emin);
                apb_write(REG_EXP_CEIL, ($urandom_range(0, 4) == 0) ?
                          $urandom_range(0, 65535) : $urandom_range(emin, 65535));
                apb_write(REG_EXP_START, $urandom_range(0, 65535));
            end
        endcase
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_frame(scene_frame(DARK_SCENE, 0));
        send_frame(scene_frame(FULL_SCENE, 0));
        send_frame(scene_frame(10, 1));
        wait_quiet();
        apb_write(REG_AUTO_ENABLE, 1);
        send_frame(scene_frame(0, 0));
        send_frame(scene_frame(0, 0));
        send_frame(scene_frame(FULL_SCENE, 0));
        send_frame(scene_frame(FULL_SCENE, 0));
        send_frame(scene_frame(200, 0));
        send_frame(scene_frame(200, 0));
        send_frame(scene_frame(35, 0));
        send_frame(scene_frame(20, 0));
        send_frame(scene_frame(20, 1));
        send_frame(scene_frame(1, 0));
        send_frame(scene_frame(40, 1));
        send_frame(scene_frame(0, 0));
        wait_quiet();
        apb_write(REG_EXP_FLOOR, 40000);
        apb_write(REG_EXP_CEIL, 20000);
        apb_write(REG_EXP_START, 50000);
        send_frame(scene_frame(0, 1));
        send_frame(scene_frame(0, 0));
        send_frame(scene_frame(0, 0));
        send_frame(scene_frame(FULL_SCENE, 0));
        wait_quiet();
        apb_write(REG_AUTO_ENABLE, 0);
        send_frame(scene_frame(DARK_SCENE, 0));
        send_frame(scene_frame(FULL_SCENE, 1));

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_quiet();
            configure(phase);
            relaxed_source = ($urandom_range(0, 3) == 0);
            relaxed_sink   = ($urandom_range(0, 3) == 0);
            repeat (PHASE_FRAMES) send_frame(random_frame());
        end

        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (predictor.mismatches == 0 && predictor.expected_stats.size() == 0) begin
            $display("auto_exposure_controller regression: pass");
        end else begin
            $display("auto_exposure_controller regression: fail");
        end
        $finish;
    end
endmodule

>>> auto_exposure_controller.f
src/aec_pkg.sv
src/aec_stream_if.sv
src/aec_regs.sv
src/aec_wsum.sv
src/aec_sat_div.sv
src/aec_scale.sv
src/auto_exposure_controller.sv
src/aec_checker.sv
tb/tb_auto_exposure_controller.sv
